>>> rtl/directional_focus_selector_core_defines.svh
// Assertion macros shared by the directional focus selector RTL.
// No dependencies; included by the top level ahead of its assertions.
`ifndef DIRECTIONAL_FOCUS_SELECTOR_CORE_DEFINES_SVH
`define DIRECTIONAL_FOCUS_SELECTOR_CORE_DEFINES_SVH

// Checks that an expression holds at every clock edge outside reset.
`define DFS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle whenever the antecedent does.
`define DFS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/dfs_pkg.sv
// Shared types, constants and geometry helpers of the directional focus selector.
// No dependencies; used by dfs_metric and directional_focus_selector_core.
package dfs_pkg;

   // Centers are clamped to [-COORD_LIMIT, COORD_LIMIT].
   localparam int COORD_LIMIT = 32767;
   localparam int DIST_W      = 16;
   localparam int SCORE_W     = $clog2((2 * COORD_LIMIT + 1) * 1024 + 2 * COORD_LIMIT + 1);
   localparam int OUT_IDX_W   = 6;
   localparam int REQ_DATA_W  = 72;
   localparam int REQ_FIELDS_W = 66;
   localparam int RSP_DATA_W  = 8;

   // Item kinds carried on tuser.
   localparam logic OPC_START = 1'b0;
   localparam logic OPC_CAND  = 1'b1;

   // Input fields, direction in the lowest bits.
   typedef struct packed {
      logic        is_current;
      logic        current_valid;
      logic [14:0] rect_height;
      logic [14:0] rect_width;
      logic [15:0] rect_y;
      logic [15:0] rect_x;
      logic [1:0]  direction;
   } req_item_type;

   // Geometry of the current target, prepared when a start item arrives.
   typedef struct packed {
      logic [15:0] ucx;
      logic [15:0] ucy;
      logic [16:0] x0;
      logic [16:0] x1;
      logic [16:0] y0;
      logic [16:0] y1;
   } cur_geom_type;

   // Per-candidate figures that feed the selection stage.
   typedef struct packed {
      logic               in_dir;
      logic               beam;
      logic [SCORE_W-1:0] score;
      logic [SCORE_W-1:0] wscore;
   } cand_metric_type;

   // Control flags of an item in the selection stage.
   typedef struct packed {
      logic is_cand;
      logic judge;
      logic no_cur;
      logic last;
   } stage_flags_type;

   // Center of a span, clamped to the coordinate limit.
   function automatic logic signed [15:0] center_of(input logic signed [15:0] edge_v,
                                                    input logic [14:0] size);
      logic signed [16:0] c;
      logic signed [16:0] lim;
      begin
         lim = 17'(COORD_LIMIT);
         c = 17'(edge_v) + $signed({3'b000, size[14:1]});
         if (c > lim) begin
            c = lim;
         end else if (c < -lim) begin
            c = -lim;
         end
         center_of = 16'(c);
      end
   endfunction

   // Absolute distance between two clamped centers.
   function automatic logic [DIST_W-1:0] abs_diff(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
      logic signed [16:0] d;
      begin
         d = 17'(a) - 17'(b);
         if (d < 0) begin
            d = -d;
         end
         abs_diff = d[DIST_W-1:0];
      end
   endfunction

endpackage

>>> rtl/directional_focus_selector_core.sv
// Top level of the directional focus selector: input, metric and selection stages.
// Depends on dfs_pkg, dfs_metric and directional_focus_selector_core_defines.svh.

// The block takes one item per clock cycle on the req_ stream while req_tready
// is high and returns a single item on the rsp_ stream for each candidate item
// that carries tlast. An item passes an input register, a metric register and
// the result register. The sustained rate is one item per cycle while no
// waiting result holds the pipeline, set by the best-so-far compare loop of the
// selection stage. A start item (tuser low) loads the key direction and the
// current rectangle; candidates (tuser high) then follow, indexed from zero, up
// to MAX_CANDIDATES per search. A waiting result does not stop the pipeline
// until an item that needs the result register reaches the selection stage.
`include "directional_focus_selector_core_defines.svh"

module directional_focus_selector_core
   import dfs_pkg::*;
#(
   parameter int MAX_CANDIDATES = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // direction[1:0], rect_x[17:2], rect_y[33:18], rect_width[48:34],
   // rect_height[63:49], current_valid[64], is_current[65], zeros above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[0]
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found[0], target_index[6:1], zero[7]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(MAX_CANDIDATES);
   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

   // Input register.
   logic          s0_valid_ff, s0_valid_in;
   req_item_type  s0_item_ff;
   logic          s0_opc_ff;
   logic          s0_last_ff;
   logic          s0_go;

   // Search context held by the metric stage.
   logic [1:0]    dir_ff;
   logic          have_cur_ff;
   cur_geom_type  geom_ff, geom_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic          counted;

   // Metric register.
   logic            s1_valid_ff, s1_valid_in;
   stage_flags_type s1_flags_ff, s1_flags_in;
   cand_metric_type s1_metric_ff, metric;
   logic [IDX_W-1:0] s1_idx_ff;
   logic            s1_emit, s1_go, s1_ready;

   // Running winners of the selection stage.
   logic               best_valid_ff, best_valid_in;
   logic               best_beam_ff, best_beam_in;
   logic [SCORE_W-1:0] best_score_ff, best_score_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               wrap_valid_ff, wrap_valid_in;
   logic [SCORE_W-1:0] wrap_score_ff, wrap_score_in;
   logic [IDX_W-1:0]   wrap_idx_ff, wrap_idx_in;
   logic               take_best, take_wrap;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [IDX_W-1:0]     sel_idx;
   logic [IDX_W+OUT_IDX_W-1:0] sel_idx_ext;
   logic                 out_free;

   // Handshake and stage advance.
   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      s1_emit = s1_flags_ff.is_cand && s1_flags_ff.last;
      s1_go = s1_valid_ff && (!s1_emit || out_free);
      s1_ready = !s1_valid_ff || s1_go;
      s0_go = s0_valid_ff && s1_ready;
      req_tready = !s0_valid_ff || s1_ready;
   end

   // Input register load.
   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (req_tvalid && req_tready) begin
         s0_valid_in = 1'b1;
      end else if (s0_go) begin
         s0_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
      if (req_tvalid && req_tready) begin
         s0_item_ff <= req_item_type'(req_tdata[REQ_FIELDS_W-1:0]);
         s0_opc_ff <= req_tuser;
         s0_last_ff <= req_tlast;
      end
   end

   // Candidate figures against the held current target.
   dfs_metric u_metric (
      .direction   (dir_ff),
      .geom        (geom_ff),
      .rect_x      (s0_item_ff.rect_x),
      .rect_y      (s0_item_ff.rect_y),
      .rect_width  (s0_item_ff.rect_width),
      .rect_height (s0_item_ff.rect_height),
      .metric      (metric)
   );

   // Current target geometry taken from a start item.
   always_comb begin
      geom_in.ucx = center_of($signed(s0_item_ff.rect_x), s0_item_ff.rect_width);
      geom_in.ucy = center_of($signed(s0_item_ff.rect_y), s0_item_ff.rect_height);
      geom_in.x0 = 17'($signed(s0_item_ff.rect_x));
      geom_in.y0 = 17'($signed(s0_item_ff.rect_y));
      geom_in.x1 = 17'($signed(s0_item_ff.rect_x)) + {2'b00, s0_item_ff.rect_width};
      geom_in.y1 = 17'($signed(s0_item_ff.rect_y)) + {2'b00, s0_item_ff.rect_height};
   end

   // Candidate numbering and item flags for the selection stage.
   always_comb begin
      counted = count_ff < CNT_W'(MAX_CANDIDATES);
      count_in = count_ff;
      if (s0_opc_ff == OPC_START || s0_last_ff) begin
         count_in = '0;
      end else if (counted) begin
         count_in = count_ff + 1'b1;
      end
      s1_flags_in.is_cand = (s0_opc_ff == OPC_CAND);
      s1_flags_in.judge = counted && have_cur_ff && !s0_item_ff.is_current &&
                          (s0_item_ff.rect_width != '0) && (s0_item_ff.rect_height != '0);
      s1_flags_in.no_cur = !have_cur_ff;
      s1_flags_in.last = s0_last_ff;
      s1_valid_in = s0_go || (s1_valid_ff && !s1_go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= '0;
         have_cur_ff <= 1'b0;
         geom_ff <= '0;
         count_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s0_go) begin
            count_ff <= count_in;
            if (s0_opc_ff == OPC_START) begin
               dir_ff <= s0_item_ff.direction;
               have_cur_ff <= s0_item_ff.current_valid;
               geom_ff <= geom_in;
            end
         end
      end
      if (s0_go) begin
         s1_flags_ff <= s1_flags_in;
         s1_metric_ff <= metric;
         s1_idx_ff <= count_ff[IDX_W-1:0];
      end
   end

   // Running winner updates; ties keep the earlier candidate.
   always_comb begin
      take_best = s1_flags_ff.judge && s1_metric_ff.in_dir &&
                  (!best_valid_ff || (s1_metric_ff.beam && !best_beam_ff) ||
                   ((s1_metric_ff.beam == best_beam_ff) &&
                    (s1_metric_ff.score < best_score_ff)));
      take_wrap = s1_flags_ff.judge &&
                  (!wrap_valid_ff || (s1_metric_ff.wscore < wrap_score_ff));
      best_valid_in = best_valid_ff || take_best;
      best_beam_in = take_best ? s1_metric_ff.beam : best_beam_ff;
      best_score_in = take_best ? s1_metric_ff.score : best_score_ff;
      best_idx_in = take_best ? s1_idx_ff : best_idx_ff;
      wrap_valid_in = wrap_valid_ff || take_wrap;
      wrap_score_in = take_wrap ? s1_metric_ff.wscore : wrap_score_ff;
      wrap_idx_in = take_wrap ? s1_idx_ff : wrap_idx_ff;
   end

   // Result of a search, taken from the updated winners.
   always_comb begin
      rsp_found_in = 1'b0;
      sel_idx = '0;
      priority if (s1_flags_ff.no_cur) begin
         rsp_found_in = 1'b1;
      end else if (best_valid_in) begin
         rsp_found_in = 1'b1;
         sel_idx = best_idx_in;
      end else if (wrap_valid_in) begin
         rsp_found_in = 1'b1;
         sel_idx = wrap_idx_in;
      end
      sel_idx_ext = {{OUT_IDX_W{1'b0}}, sel_idx};
      rsp_idx_in = sel_idx_ext[OUT_IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_go && s1_emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Winner registers clear at a start item and after the last candidate.
   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
         best_beam_ff <= 1'b0;
         best_score_ff <= '1;
         best_idx_ff <= '0;
         wrap_valid_ff <= 1'b0;
         wrap_score_ff <= '1;
         wrap_idx_ff <= '0;
      end else if (s1_go) begin
         if (!s1_flags_ff.is_cand || s1_flags_ff.last) begin
            best_valid_ff <= 1'b0;
            best_beam_ff <= 1'b0;
            best_score_ff <= '1;
            best_idx_ff <= '0;
            wrap_valid_ff <= 1'b0;
            wrap_score_ff <= '1;
            wrap_idx_ff <= '0;
         end else begin
            best_valid_ff <= best_valid_in;
            best_beam_ff <= best_beam_in;
            best_score_ff <= best_score_in;
            best_idx_ff <= best_idx_in;
            wrap_valid_ff <= wrap_valid_in;
            wrap_score_ff <= wrap_score_in;
            wrap_idx_ff <= wrap_idx_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_go && s1_emit) begin
         rsp_found_ff <= rsp_found_in;
         rsp_idx_ff <= rsp_idx_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, rsp_idx_ff, rsp_found_ff};

   // A new result only appears after a last candidate left the selection stage.
   `DFS_ASSERT_IMPLY(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff), $past(s1_go && s1_emit), "result without a last candidate")
   // The candidate counter never runs past the search limit.
   `DFS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_CANDIDATES), "candidate count past limit")
   // A beam winner is always a valid winner.
   `DFS_ASSERT_IMPLY(a_beam_valid, clock, reset, best_beam_ff, best_valid_ff, "beam flag without a winner")
   // A blocked input register keeps its item.
   `DFS_ASSERT_IMPLY(a_s0_hold, clock, reset, $past(s0_valid_ff && !s1_ready) && !$past(reset), s0_valid_ff && $stable(s0_item_ff), "input register lost a stalled item")

endmodule

>>> rtl/dfs_metric.sv
// Direction, beam and score figures of one candidate against the current target.
// Depends on dfs_pkg for the geometry types and helper functions.
module dfs_metric
   import dfs_pkg::*;
(
   input  logic [1:0]      direction,
   input  cur_geom_type    geom,
   input  logic [15:0]     rect_x,
   input  logic [15:0]     rect_y,
   input  logic [14:0]     rect_width,
   input  logic [14:0]     rect_height,
   output cand_metric_type metric
);

   logic                signed [15:0] ccx, ccy, cu, uu;
   logic                horiz, fwd;
   logic [DIST_W-1:0]   dx, dy, primary, secondary;
   logic signed [16:0]  a0, a1, b0, b1;
   logic signed [16:0]  rank_s;
   logic [DIST_W-1:0]   rank, edge_rank;

   // Centers and distances along and across the key axis.
   always_comb begin
      ccx = center_of($signed(rect_x), rect_width);
      ccy = center_of($signed(rect_y), rect_height);
      horiz = direction[1];
      fwd = direction[0];
      cu = horiz ? ccx : ccy;
      uu = horiz ? $signed(geom.ucx) : $signed(geom.ucy);
      dx = abs_diff(ccx, $signed(geom.ucx));
      dy = abs_diff(ccy, $signed(geom.ucy));
      primary = horiz ? dx : dy;
      secondary = horiz ? dy : dx;
   end

   // Beam overlap on the cross axis.
   always_comb begin
      a0 = horiz ? $signed(geom.y0) : $signed(geom.x0);
      a1 = horiz ? $signed(geom.y1) : $signed(geom.x1);
      b0 = horiz ? 17'($signed(rect_y)) : 17'($signed(rect_x));
      b1 = b0 + $signed({2'b00, horiz ? rect_height : rect_width});
   end

   // Wrap rank toward the opposite screen edge.
   always_comb begin
      rank_s = 17'(cu) + 17'(COORD_LIMIT);
      rank = rank_s[DIST_W-1:0];
      edge_rank = fwd ? rank : DIST_W'(2 * COORD_LIMIT + 1) - rank;
   end

   // Figures handed to the selection stage.
   always_comb begin
      metric.in_dir = fwd ? (cu > uu) : (cu < uu);
      metric.beam = (a0 < b1) && (b0 < a1);
      metric.score = SCORE_W'({primary, 10'b0}) + SCORE_W'(secondary);
      metric.wscore = SCORE_W'({edge_rank, 10'b0}) + SCORE_W'(secondary);
   end

endmodule
